// ----- src/ssd_pkg.sv -----
package ssd_pkg;

    typedef enum logic [4:0] {
        FMT_IBM  = 5'd1,
        FMT_I32  = 5'd2,
        FMT_I16  = 5'd3,
        FMT_F32  = 5'd5,
        FMT_F64  = 5'd6,
        FMT_I24  = 5'd7,
        FMT_I8   = 5'd8,
        FMT_I64  = 5'd9,
        FMT_U32  = 5'd10,
        FMT_U16  = 5'd11,
        FMT_U64  = 5'd12,
        FMT_U24  = 5'd15,
        FMT_U8   = 5'd16
    } fmt_t;

    localparam logic REG_FORMAT = 1'b0;
    localparam logic REG_ORDER  = 1'b1;

    localparam logic [4:0] FORMAT_RESET = 5'd1;

    // leading one position of a 64-bit word
    function automatic logic [5:0] top_bit(input logic [63:0] v);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

endpackage

// ----- src/seismic_sample_to_double.sv -----
// seismic sample to ieee binary64 converter
// a start transfer passes the stage 1, 2 and 3 registers and the output register before the done strobe
// throughput: one sample per cycle, start may be high every cycle, busy stays low
// the receiver cannot stall; each result is shown for exactly one cycle on done
// reset (rst_n low, asynchronous): pipeline emptied, sample_format 1, byte_order 0
module seismic_sample_to_double (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] raw_sample,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output logic        done,
    output logic [63:0] sample_value,
    output logic        format_error
);
    import ssd_pkg::*;

    // configuration registers
    logic [4:0] fmt_reg;
    logic       order_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg   <= FORMAT_RESET;
            order_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == 5'(REG_FORMAT))
            begin
                fmt_reg <= cfg_data[4:0];
            end
            else if (cfg_index == 5'(REG_ORDER))
            begin
                order_reg <= cfg_data[0];
            end
        end
    end

    // ---------------- stage 1: byte gather and sign split ----------------
    logic [3:0]  nbytes;
    logic        is_signed;
    logic        kind_int;   // integer path
    logic        kind_ibm;
    logic        kind_f32;
    logic        kind_f64;
    logic        fmt_bad;
    logic [63:0] gathered;
    logic [63:0] sign_mask;

    always_comb
    begin
        nbytes    = 4'd4;
        is_signed = 1'b0;
        kind_int  = 1'b0;
        kind_ibm  = 1'b0;
        kind_f32  = 1'b0;
        kind_f64  = 1'b0;
        fmt_bad   = 1'b0;
        case (fmt_reg)
            FMT_IBM: kind_ibm = 1'b1;
            FMT_F32: kind_f32 = 1'b1;
            FMT_F64: begin kind_f64 = 1'b1; nbytes = 4'd8; end
            FMT_I32: begin kind_int = 1'b1; is_signed = 1'b1; end
            FMT_I16: begin kind_int = 1'b1; is_signed = 1'b1; nbytes = 4'd2; end
            FMT_I24: begin kind_int = 1'b1; is_signed = 1'b1; nbytes = 4'd3; end
            FMT_I8:  begin kind_int = 1'b1; is_signed = 1'b1; nbytes = 4'd1; end
            FMT_I64: begin kind_int = 1'b1; is_signed = 1'b1; nbytes = 4'd8; end
            FMT_U32: kind_int = 1'b1;
            FMT_U16: begin kind_int = 1'b1; nbytes = 4'd2; end
            FMT_U64: begin kind_int = 1'b1; nbytes = 4'd8; end
            FMT_U24: begin kind_int = 1'b1; nbytes = 4'd3; end
            FMT_U8:  begin kind_int = 1'b1; nbytes = 4'd1; end
            default: fmt_bad = 1'b1;
        endcase
    end

    // little-endian: keep low bytes; big-endian: first byte lands on top
    always_comb
    begin
        gathered = 64'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < nbytes)
            begin
                if (order_reg)
                begin
                    gathered[8*i +: 8] = raw_sample[8*i +: 8];
                end
                else
                begin
                    gathered[8*(int'(nbytes)-1-i) +: 8] = raw_sample[8*i +: 8];
                end
            end
        end
        sign_mask = 64'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i + 1) == nbytes)
            begin
                sign_mask[8*i+7] = 1'b1;
            end
        end
    end

    logic        s1_valid_reg;
    logic [63:0] s1_word_reg;
    logic        s1_neg_reg;
    logic        s1_int_reg, s1_ibm_reg, s1_f32_reg, s1_f64_reg, s1_bad_reg;

    logic        neg_next;
    logic [63:0] word_next;

    always_comb
    begin
        neg_next  = kind_int && is_signed && ((gathered & sign_mask) != 64'd0);
        // two's complement magnitude within the sample width
        word_next = neg_next ? (64'd0 - (gathered | ~((sign_mask << 1) - 64'd1)))
                             : gathered;
        if (neg_next && nbytes == 4'd8)
        begin
            word_next = 64'd0 - gathered;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_word_reg <= word_next;
        s1_neg_reg  <= neg_next;
        s1_int_reg  <= kind_int;
        s1_ibm_reg  <= kind_ibm;
        s1_f32_reg  <= kind_f32;
        s1_f64_reg  <= kind_f64;
        s1_bad_reg  <= fmt_bad;
    end

    // ---------------- stage 2: leading one search ----------------
    // mantissa source: integer magnitude, ibm fraction or single fraction
    logic [63:0] mant;
    logic        s1_sign;
    logic        f32_special;   // inf or nan, or normal single: no normalize

    always_comb
    begin
        if (s1_ibm_reg)
        begin
            mant = {40'd0, s1_word_reg[23:0]};
        end
        else if (s1_f32_reg)
        begin
            mant = {41'd0, s1_word_reg[22:0]};
        end
        else
        begin
            mant = s1_word_reg;
        end
        s1_sign     = (s1_ibm_reg || s1_f32_reg) ? s1_word_reg[31] : s1_neg_reg;
        f32_special = s1_word_reg[30:23] != 8'd0;
    end

    logic        s2_valid_reg;
    logic [63:0] s2_word_reg;
    logic [63:0] s2_mant_reg;
    logic [5:0]  s2_p_reg;
    logic        s2_sign_reg, s2_zero_reg, s2_spec_reg;
    logic        s2_int_reg, s2_ibm_reg, s2_f32_reg, s2_f64_reg, s2_bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_word_reg <= s1_word_reg;
        s2_mant_reg <= mant;
        s2_p_reg    <= top_bit(mant);
        s2_sign_reg <= s1_sign;
        s2_zero_reg <= mant == 64'd0;
        s2_spec_reg <= f32_special;
        s2_int_reg  <= s1_int_reg;
        s2_ibm_reg  <= s1_ibm_reg;
        s2_f32_reg  <= s1_f32_reg;
        s2_f64_reg  <= s1_f64_reg;
        s2_bad_reg  <= s1_bad_reg;
    end

    // ---------------- stage 3: normalize shift and rounding bits ----------------
    logic [63:0] norm;       // leading one moved to bit 63
    logic [52:0] kept;
    logic        round_up;
    logic [10:0] exp_base;

    always_comb
    begin
        norm     = s2_mant_reg << (6'd63 - s2_p_reg);
        kept     = norm[63:11];
        // rounding only matters past 53 significant bits
        round_up = norm[10] && ((norm[9:0] != 10'd0) || norm[11]);
        if (s2_ibm_reg)
        begin
            exp_base = 11'(s2_p_reg) + {2'b00, s2_word_reg[30:24], 2'b00} + 11'd743;
        end
        else if (s2_f32_reg)
        begin
            exp_base = 11'(s2_p_reg) + 11'd874;
        end
        else
        begin
            exp_base = 11'(s2_p_reg) + 11'd1023;
        end
    end

    logic        s3_valid_reg;
    logic [63:0] s3_word_reg;
    logic [52:0] s3_kept_reg;
    logic        s3_up_reg;
    logic [10:0] s3_exp_reg;
    logic        s3_sign_reg, s3_zero_reg, s3_spec_reg;
    logic        s3_int_reg, s3_f32_reg, s3_f64_reg, s3_bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_word_reg <= s2_word_reg;
        s3_kept_reg <= kept;
        s3_up_reg   <= round_up;
        s3_exp_reg  <= exp_base;
        s3_sign_reg <= s2_sign_reg;
        s3_zero_reg <= s2_zero_reg;
        s3_spec_reg <= s2_spec_reg;
        s3_int_reg  <= s2_int_reg;
        s3_f32_reg  <= s2_f32_reg;
        s3_f64_reg  <= s2_f64_reg;
        s3_bad_reg  <= s2_bad_reg;
    end

    // ---------------- stage 4: round, pack, output register ----------------
    logic [53:0] rounded;
    logic [10:0] exp_fin;
    logic [51:0] frac_fin;
    logic [63:0] value_next;
    logic [7:0]  f32_exp;

    always_comb
    begin
        rounded  = {1'b0, s3_kept_reg} + 54'(s3_up_reg);
        exp_fin  = s3_exp_reg;
        frac_fin = rounded[51:0];
        if (rounded[53])
        begin
            exp_fin  = s3_exp_reg + 11'd1;
            frac_fin = rounded[52:1];
        end
        f32_exp = s3_word_reg[30:23];

        if (s3_bad_reg)
        begin
            value_next = 64'd0;
        end
        else if (s3_f64_reg)
        begin
            value_next = s3_word_reg;
        end
        else if (s3_f32_reg && s3_spec_reg)
        begin
            if (f32_exp == 8'hFF)
            begin
                // payload at the top of the fraction, quiet bit forced on a nan
                value_next = {s3_sign_reg, 11'h7FF,
                              s3_word_reg[22] | (s3_word_reg[22:0] != 23'd0),
                              s3_word_reg[21:0], 29'd0};
            end
            else
            begin
                value_next = {s3_sign_reg, 11'(f32_exp) + 11'd896,
                              s3_word_reg[22:0], 29'd0};
            end
        end
        else if (s3_zero_reg)
        begin
            value_next = {(s3_int_reg ? 1'b0 : s3_sign_reg), 63'd0};
        end
        else
        begin
            value_next = {s3_sign_reg, exp_fin, frac_fin};
        end
    end

    logic        done_reg;
    logic [63:0] value_reg;
    logic        err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        err_reg   <= s3_bad_reg;
    end

    assign done         = done_reg;
    assign sample_value = value_reg;
    assign format_error = err_reg;

    // ---------------- checks ----------------
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##4 done)
        else $error("result strobe missing four cycles after start");

    a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done && format_error) |-> (sample_value == 64'd0))
        else $error("format error with nonzero value");

    a_no_extra : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 4))
        else $error("result strobe without a matching start");

endmodule

// ----- dv/sample_value_checker.sv -----
module sample_value_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [63:0] raw_sample,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [4:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        done,
    input  logic [63:0] sample_value,
    input  logic        format_error,
    output int          fail_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import ssd_pkg::*;

    typedef struct packed {
        logic [63:0] value;
        logic        err;
    } conversion_t;

    conversion_t expected_q[$];
    logic [4:0]  cur_format;
    logic        cur_little;

    function automatic logic [63:0] assemble_bytes(input logic [63:0] raw, input int n,
                                                   input logic little);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++)
        begin
            if (little)
                v[8*i +: 8] = raw[8*i +: 8];
            else
                v = {v[55:0], raw[8*i +: 8]};
        end
        return v;
    endfunction

    function automatic int msb_index(input logic [63:0] v);
        int p;
        p = 0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
                p = i;
        end
        return p;
    endfunction

    // integer magnitude to binary64, nearest even
    function automatic logic [63:0] magnitude_to_double(input logic neg, input logic [63:0] mag);
        int          p;
        int          sh;
        logic [63:0] kept;
        logic [63:0] rem;
        logic [63:0] half;
        if (mag == 0)
            return '0;
        p = msb_index(mag);
        if (p <= 52)
        begin
            kept = mag << (52 - p);
        end
        else
        begin
            sh   = p - 52;
            rem  = mag & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            kept = mag >> sh;
            if (rem > half || (rem == half && kept[0]))
                kept = kept + 64'd1;
            if (kept == (64'd1 << 53))
            begin
                kept = kept >> 1;
                p++;
            end
        end
        return {neg, 11'(p + 1023), kept[51:0]};
    endfunction

    function automatic logic [63:0] twos_to_double(input logic [63:0] v, input int bits);
        logic [63:0] mask;
        mask = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
        if (v[bits-1])
            return magnitude_to_double(1'b1, (~v + 64'd1) & mask);
        return magnitude_to_double(1'b0, v);
    endfunction

    function automatic logic [63:0] hex_float_to_double(input logic [63:0] w);
        logic [63:0] fr;
        int          p;
        fr = {40'd0, w[23:0]};
        // zero fraction keeps only the sign
        if (fr == 0)
            return {w[31], 63'd0};
        p = msb_index(fr);
        return {w[31], 11'(p + 4 * int'(w[30:24]) + 743), 52'(fr << (52 - p))};
    endfunction

    function automatic logic [63:0] single_to_double(input logic [63:0] w);
        logic [63:0] fr;
        int          p;
        fr = {41'd0, w[22:0]};
        if (w[30:23] == 8'hff)
        begin
            if (fr == 0)
                return {w[31], 11'h7ff, 52'd0};
            // nan: payload moved up, quiet bit forced
            return {w[31], 11'h7ff, w[22:0], 29'd0} | (64'd1 << 51);
        end
        if (w[30:23] == 8'h00)
        begin
            if (fr == 0)
                return {w[31], 63'd0};
            p = msb_index(fr);
            return {w[31], 11'(p + 874), 52'(fr << (52 - p))};
        end
        return {w[31], 11'(int'(w[30:23]) + 896), w[22:0], 29'd0};
    endfunction

    function automatic conversion_t convert_sample(input logic [63:0] raw);
        conversion_t r;
        r.err = 1'b0;
        case (cur_format)
            FMT_IBM: r.value = hex_float_to_double(assemble_bytes(raw, 4, cur_little));
            FMT_I32: r.value = twos_to_double(assemble_bytes(raw, 4, cur_little), 32);
            FMT_I16: r.value = twos_to_double(assemble_bytes(raw, 2, cur_little), 16);
            FMT_F32: r.value = single_to_double(assemble_bytes(raw, 4, cur_little));
            FMT_F64: r.value = assemble_bytes(raw, 8, cur_little);
            FMT_I24: r.value = twos_to_double(assemble_bytes(raw, 3, cur_little), 24);
            FMT_I8:  r.value = twos_to_double(assemble_bytes(raw, 1, cur_little), 8);
            FMT_I64: r.value = twos_to_double(assemble_bytes(raw, 8, cur_little), 64);
            FMT_U32: r.value = magnitude_to_double(1'b0, assemble_bytes(raw, 4, cur_little));
            FMT_U16: r.value = magnitude_to_double(1'b0, assemble_bytes(raw, 2, cur_little));
            FMT_U64: r.value = magnitude_to_double(1'b0, assemble_bytes(raw, 8, cur_little));
            FMT_U24: r.value = magnitude_to_double(1'b0, assemble_bytes(raw, 3, cur_little));
            FMT_U8:  r.value = magnitude_to_double(1'b0, assemble_bytes(raw, 1, cur_little));
            default:
            begin
                r.value = '0;
                r.err   = 1'b1;
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        conversion_t exp_c;
        if (!rst_n)
        begin
            cur_format = FORMAT_RESET;
            cur_little = 1'b0;
            expected_q.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result value=%h error=%b", sample_value, format_error);
                    fail_count++;
                end
                else
                begin
                    exp_c = expected_q.pop_front();
                    if (sample_value !== exp_c.value)
                    begin
                        $error("sample_value expected %h actual %h", exp_c.value, sample_value);
                        fail_count++;
                    end
                    if (format_error !== exp_c.err)
                    begin
                        $error("format_error expected %b actual %b", exp_c.err, format_error);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                expected_q.push_back(convert_sample(raw_sample));
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == 5'(REG_FORMAT))
                    cur_format = cfg_data[4:0];
                else if (cfg_index == 5'(REG_ORDER))
                    cur_little = cfg_data[0];
            end
            outstanding = expected_q.size();
        end
    end

    final
    begin
    end

endmodule

// ----- dv/tb_seismic_sample_to_double.sv -----
module tb_seismic_sample_to_double;
    timeunit 1ns;
    timeprecision 1ps;
    import ssd_pkg::*;

    localparam int SAMPLES_PER_SETTING = 21;
    localparam int STALL_LIMIT         = 20000;
    localparam int DRAIN_CYCLES        = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [63:0] raw_sample = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        done;
    logic [63:0] sample_value;
    logic        format_error;
    int          fail_count;
    int          outstanding;
    int          quiet_cycles = 0;

    // corner samples for the reset setting (ibm, big-endian), in file byte order
    logic [63:0] corner_samples[] = '{
        64'h0,                     // positive zero
        64'hffff_ffff_ffff_ffff,   // all ones
        64'h0000_0000_0000_0080,   // ibm negative zero fraction
        64'h0000_0000_0000_0041,   // zero fraction with exponent
        64'h0100_0000_0000_0041,   // zero fraction with exponent, top byte set but unused
        64'h0000_0000_0100_0000,   // smallest fraction, exponent zero
        64'hffff_ff00_ffff_ff7f,   // largest exponent and fraction
        64'h8000_0000_0000_0000,   // top byte unused
        64'h0000_0000_0000_0001
    };

    always #1 clk = ~clk;

    seismic_sample_to_double i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .raw_sample   (raw_sample),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .sample_value (sample_value),
        .format_error (format_error)
    );

    sample_value_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .raw_sample   (raw_sample),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .sample_value (sample_value),
        .format_error (format_error),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    // mostly back to back, a few short gaps, rarely a long one
    function automatic int pick_gap(input bit no_gaps);
        if (no_gaps || $urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // bytes biased toward sign, exponent and rounding corners
    function automatic logic [63:0] random_sample();
        logic [63:0] v;
        if ($urandom_range(0, 3) == 0)
            return {$urandom(), $urandom()};
        for (int i = 0; i < 8; i++)
        begin
            case ($urandom_range(0, 5))
                0: v[8*i +: 8] = 8'h00;
                1: v[8*i +: 8] = 8'hff;
                2: v[8*i +: 8] = 8'h80;
                3: v[8*i +: 8] = 8'h7f;
                default: v[8*i +: 8] = 8'($urandom());
            endcase
        end
        return v;
    endfunction

    // one sample transfer; start stays high afterward, caller lowers it on a gap
    task automatic send_sample(input logic [63:0] raw);
        start      <= 1'b1;
        raw_sample <= raw;
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
    endtask

    task automatic idle_after(input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write; upper data bits carry noise the block must ignore
    task automatic write_register(input logic [4:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        repeat ($urandom_range(0, 3)) @(posedge clk);
    endtask

    // watchdog: cycles with no transfer of any kind
    always @(posedge clk)
    begin
        if ((start && !busy) || (cfg_valid && cfg_ready) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("seismic_sample_to_double verification failed");
            $finish;
        end
    end

    initial
    begin
        int gap;
        bit no_gaps;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed corners under the reset setting
        foreach (corner_samples[k])
        begin
            send_sample(corner_samples[k]);
            idle_after(pick_gap(1'b0));
        end
        start <= 1'b0;

        // sweep every format code, big-endian then little-endian
        for (int order = 0; order < 2; order++)
        begin
            for (int code = 0; code < 32; code++)
            begin
                wait_drained();
                write_register(5'(REG_FORMAT), {$urandom(), $urandom()} & ~64'h1f | 64'(code));
                write_register(5'(REG_ORDER), {$urandom(), $urandom()} & ~64'h1 | 64'(order));
                no_gaps = (code % 4 == 0);
                for (int n = 0; n < SAMPLES_PER_SETTING; n++)
                begin
                    send_sample(random_sample());
                    gap = pick_gap(no_gaps);
                    // hold off once mid-stream until the pipeline is empty
                    if (order == 0 && code == 3 && n == 10)
                    begin
                        start <= 1'b0;
                        do
                            @(posedge clk);
                        while (outstanding != 0);
                    end
                    else
                    begin
                        idle_after(gap);
                    end
                end
                start <= 1'b0;
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("seismic_sample_to_double verification clean");
        else
            $display("seismic_sample_to_double verification failed");
        $finish;
    end

endmodule
